FILE: src/daoa_pkg.sv
// Shared types and constants of the dual ADC oversampling accumulator.
// No dependencies; used by the interfaces, the conversion unit and the top level.
package daoa_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 16;
    localparam int CODE_W   = 14;
    localparam int MV_W     = 12;
    localparam int VREF_W   = 12;
    localparam int TEMP_W   = 17;
    localparam int CHAN_W   = 3;

    localparam logic [SUM_W-1:0]  SUM_MAX  = 16'hFFFF;
    localparam logic [CODE_W-1:0] CODE_MAX = 14'd16383;

    // temperature constants: 2500 + ((1430 - mv) * 1000) / 43
    localparam logic signed [15:0] TEMP_MV_REF  = 16'sd1430;
    localparam logic [9:0]         TEMP_SCALE   = 10'd1000;
    localparam logic signed [20:0] TEMP_OFFSET  = 21'sd2500;
    // floor(x / 43) == (x * DIV43_MUL) >> DIV43_SHIFT for every x below 2**24
    localparam logic [24:0]        DIV43_MUL    = 25'd24970741;
    localparam int                 DIV43_SHIFT  = 30;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CHANNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_PERIOD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VREF_MV      = 2'd2;

    localparam logic [CHAN_W-1:0] RST_TEMP_CHANNEL = 3'd4;
    localparam logic [15:0]       RST_LED_PERIOD   = 16'd500;
    localparam logic [VREF_W-1:0] RST_VREF_MV      = 12'd3300;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  sum;
        logic [VREF_W-1:0] vref;
    } t_conv_req;

    typedef struct packed {
        logic                     done;
        logic [CODE_W-1:0]        code;
        logic [MV_W-1:0]          mv;
        logic signed [TEMP_W-1:0] temp;
    } t_conv_res;

endpackage

FILE: src/daoa_in_if.sv
// Sample pair request channel: valid/ready handshake with two 12-bit samples.
// Depends on daoa_pkg.
interface daoa_in_if;
    logic                          valid;
    logic                          ready;
    logic [daoa_pkg::SAMPLE_W-1:0] sample_first;
    logic [daoa_pkg::SAMPLE_W-1:0] sample_second;

    modport source (output valid, output sample_first, output sample_second, input ready);
    modport sink   (input valid, input sample_first, input sample_second, output ready);
endinterface

FILE: src/daoa_out_if.sv
// Per-channel result channel: valid/ready handshake with code, voltage and temperature.
// Depends on daoa_pkg.
interface daoa_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [daoa_pkg::CHAN_W-1:0]          channel;
    logic [daoa_pkg::CODE_W-1:0]          averaged_code;
    logic [11:0]                          voltage_mv;
    logic signed [daoa_pkg::TEMP_W-1:0]   temperature_centi;
    logic                                 is_temperature;
    logic                                 activity;
    logic                                 last;

    modport source (output valid, output channel, output averaged_code, output voltage_mv,
                    output temperature_centi, output is_temperature, output activity,
                    output last, input ready);
    modport sink   (input valid, input channel, input averaged_code, input voltage_mv,
                    input temperature_centi, input is_temperature, input activity,
                    input last, output ready);
endinterface

FILE: src/dual_adc_oversample_accumulator_unit.sv
// Dual ADC oversampling accumulator: sums channel pairs over a block of rounds and
// reports one converted result per channel at the end of each block.
//
// i_in carries one request per simultaneous sample pair (even and odd channel of the
// current pair); pairs cycle in order and a block is SAMPLES_PER_BLOCK rounds over all
// pairs. The channel sums live in one RAM entry per pair, read on accept and written
// back in the following cycle; no new pair is accepted until the write-back is done.
// After the last pair of a block, o_out delivers one result per channel in ascending
// order, the final one flagged with last. Each result takes a RAM read, the conversion
// unit's stages (scale multiply, temperature multiply, reciprocal multiply for the
// divide by 43, offset), a wait state that sees it done and the output register load.
// While results are being produced, i_in is held not ready; once the final result
// sits in the output register, new pairs are accepted again.
// A stalled receiver holds the output register and the sequencer waits behind it.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once and are
// meant for idle periods. Reset (i_rst_n, synchronous) returns the pair, round and
// block counters and the activity flag to zero and the registers to their defaults;
// the sum RAM needs no clearing since the first round of a block overwrites it.
module dual_adc_oversample_accumulator_unit #(
    parameter int NUM_CHANNELS      = 6,
    parameter int SAMPLES_PER_BLOCK = 16,
    parameter int OVERSAMPLE_SHIFT  = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    daoa_in_if.sink                           i_in,
    daoa_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [daoa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [daoa_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int NUM_PAIRS = NUM_CHANNELS / 2;
    localparam int PW        = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;
    localparam int CW        = PW + 1;
    localparam int RW        = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;
    localparam int SUM_W     = daoa_pkg::SUM_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ACC    = 6'b000010,
        S_EREAD  = 6'b000100,
        S_ESTART = 6'b001000,
        S_EWAIT  = 6'b010000,
        S_EOUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [daoa_pkg::CHAN_W-1:0] r_temp_channel;
    logic [15:0]                 r_led_period;
    logic [daoa_pkg::VREF_W-1:0] r_vref;

    logic [PW-1:0]  r_pair;
    logic [RW-1:0]  r_round;
    logic [15:0]    r_block_count;
    logic           r_activity;
    logic [CW-1:0]  r_ch;
    logic [daoa_pkg::SAMPLE_W-1:0] r_a, r_b;

    logic                                r_out_valid;
    logic [daoa_pkg::CHAN_W-1:0]         r_out_channel;
    logic [daoa_pkg::CODE_W-1:0]         r_out_code;
    logic [11:0]                         r_out_mv;
    logic signed [daoa_pkg::TEMP_W-1:0]  r_out_temp;
    logic                                r_out_is_t;
    logic                                r_out_activity;
    logic                                r_out_last;

    logic [2*SUM_W-1:0] ram_rdata, ram_wdata;
    logic [PW-1:0]      ram_raddr;
    logic               ram_we;

    daoa_pkg::t_conv_req conv_req;
    daoa_pkg::t_conv_res conv_res;

    logic in_fire, out_free, pair_last, round_last, first, ch_last, is_t;
    logic [16:0] next_count;

    function automatic logic [SUM_W-1:0] acc_sample(input logic [SUM_W-1:0] sum,
                                                    input logic [daoa_pkg::SAMPLE_W-1:0] smp,
                                                    input logic fst);
        logic [SUM_W:0] s;
        s = {1'b0, sum} + {5'd0, smp};
        if (fst) begin
            return {4'd0, smp};
        end
        return s[SUM_W] ? daoa_pkg::SUM_MAX : s[SUM_W-1:0];
    endfunction

    assign in_fire    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign pair_last  = r_pair == PW'(NUM_PAIRS - 1);
    assign round_last = r_round == RW'(SAMPLES_PER_BLOCK - 1);
    assign first      = r_round == '0;
    assign ch_last    = r_ch == CW'(2 * NUM_PAIRS - 1);
    assign is_t       = int'(r_ch) == int'(r_temp_channel);
    assign next_count = {1'b0, r_block_count} + 17'd1;

    assign i_in.ready = r_state == S_IDLE;

    // even channel in the low half, odd channel in the high half
    assign ram_we    = r_state == S_ACC;
    assign ram_wdata = {acc_sample(ram_rdata[2*SUM_W-1:SUM_W], r_b, first),
                        acc_sample(ram_rdata[SUM_W-1:0], r_a, first)};
    assign ram_raddr = (r_state == S_IDLE) ? r_pair : r_ch[CW-1:1];

    daoa_ram #(
        .WIDTH (2 * SUM_W),
        .DEPTH (NUM_PAIRS)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pair),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        conv_req.start = r_state == S_ESTART;
        conv_req.sum   = r_ch[0] ? ram_rdata[2*SUM_W-1:SUM_W] : ram_rdata[SUM_W-1:0];
        conv_req.vref  = r_vref;
    end

    daoa_conv #(
        .OVERSAMPLE_SHIFT (OVERSAMPLE_SHIFT)
    ) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (conv_req),
        .o_res   (conv_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = (pair_last && round_last) ? S_EREAD : S_IDLE;
            end
            S_EREAD:  n_state = S_ESTART;
            S_ESTART: n_state = S_EWAIT;
            S_EWAIT: begin
                if (conv_res.done) begin
                    n_state = S_EOUT;
                end
            end
            S_EOUT: begin
                if (out_free) begin
                    n_state = ch_last ? S_IDLE : S_EREAD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_temp_channel <= daoa_pkg::RST_TEMP_CHANNEL;
            r_led_period   <= daoa_pkg::RST_LED_PERIOD;
            r_vref         <= daoa_pkg::RST_VREF_MV;
            r_pair         <= '0;
            r_round        <= '0;
            r_block_count  <= '0;
            r_activity     <= 1'b0;
            r_ch           <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    daoa_pkg::CFG_TEMP_CHANNEL: r_temp_channel <= i_cfg_data[2:0];
                    daoa_pkg::CFG_LED_PERIOD:   r_led_period   <= i_cfg_data;
                    daoa_pkg::CFG_VREF_MV:      r_vref         <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (r_state == S_ACC) begin
                if (pair_last) begin
                    r_pair <= '0;
                    if (round_last) begin
                        r_round <= '0;
                        r_ch    <= '0;
                        // advance the block counter; passing the period toggles the flag
                        if (next_count > {1'b0, r_led_period}) begin
                            r_block_count <= '0;
                            r_activity    <= !r_activity;
                        end else begin
                            r_block_count <= next_count[15:0];
                        end
                    end else begin
                        r_round <= r_round + 1'b1;
                    end
                end else begin
                    r_pair <= r_pair + 1'b1;
                end
            end
            if (r_state == S_EOUT && out_free) begin
                r_out_valid <= 1'b1;
                if (!ch_last) begin
                    r_ch <= r_ch + 1'b1;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a <= i_in.sample_first;
            r_b <= i_in.sample_second;
        end
        if (r_state == S_EOUT && out_free) begin
            r_out_channel  <= daoa_pkg::CHAN_W'(r_ch);
            r_out_code     <= conv_res.code;
            r_out_mv       <= conv_res.mv;
            r_out_temp     <= is_t ? conv_res.temp : '0;
            r_out_is_t     <= is_t;
            r_out_activity <= r_activity;
            r_out_last     <= ch_last;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.channel           = r_out_channel;
    assign o_out.averaged_code     = r_out_code;
    assign o_out.voltage_mv        = r_out_mv;
    assign o_out.temperature_centi = r_out_temp;
    assign o_out.is_temperature    = r_out_is_t;
    assign o_out.activity          = r_out_activity;
    assign o_out.last              = r_out_last;
endmodule

FILE: src/daoa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module daoa_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 4,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/daoa_conv.sv
// Four-stage conversion of one channel sum into code, millivolts and temperature.
// Depends on daoa_pkg (t_conv_req, t_conv_res, division constants).
module daoa_conv #(
    parameter int OVERSAMPLE_SHIFT = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  daoa_pkg::t_conv_req i_req,
    output daoa_pkg::t_conv_res o_res
);
    localparam int MV_SHIFT = 12 + OVERSAMPLE_SHIFT;

    logic [3:0]                           r_v;
    logic [daoa_pkg::CODE_W-1:0]          r_code;
    logic [daoa_pkg::CODE_W+daoa_pkg::VREF_W-1:0] r_prod;
    logic [daoa_pkg::MV_W-1:0]            r_mv;
    logic [23:0]                          r_mag;
    logic                                 r_neg;
    logic [19:0]                          r_q;
    logic signed [daoa_pkg::TEMP_W-1:0]   r_temp;

    logic [daoa_pkg::SUM_W-1:0]  sum_shifted;
    logic [daoa_pkg::CODE_W-1:0] code;
    logic [daoa_pkg::MV_W-1:0]   mv;
    logic signed [15:0]          diff;
    logic [14:0]                 mag;
    logic [48:0]                 q_prod;
    logic signed [20:0]          q_signed;
    logic signed [20:0]          temp_full;

    always_comb begin
        sum_shifted = i_req.sum >> OVERSAMPLE_SHIFT;
        code = (sum_shifted > {2'b00, daoa_pkg::CODE_MAX}) ? daoa_pkg::CODE_MAX
                                                           : sum_shifted[daoa_pkg::CODE_W-1:0];
        mv   = daoa_pkg::MV_W'(r_prod >> MV_SHIFT);
        diff = daoa_pkg::TEMP_MV_REF - $signed({4'b0000, mv});
        mag  = (diff < 0) ? 15'(-diff) : 15'(diff);
        q_prod = {25'd0, r_mag} * {24'd0, daoa_pkg::DIV43_MUL};
        q_signed  = $signed({1'b0, r_q});
        // truncate toward zero: divide the magnitude, then restore the sign
        temp_full = daoa_pkg::TEMP_OFFSET + (r_neg ? -q_signed : q_signed);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_req.start};
        end
        if (i_req.start) begin
            r_code <= code;
            r_prod <= {{daoa_pkg::VREF_W{1'b0}}, code} * {{daoa_pkg::CODE_W{1'b0}}, i_req.vref};
        end
        if (r_v[0]) begin
            r_mv  <= mv;
            r_neg <= diff < 0;
            r_mag <= 24'({10'd0, mag} * {15'd0, daoa_pkg::TEMP_SCALE});
        end
        if (r_v[1]) begin
            r_q <= 20'(q_prod >> daoa_pkg::DIV43_SHIFT);
        end
        if (r_v[2]) begin
            r_temp <= daoa_pkg::TEMP_W'(temp_full);
        end
    end

    always_comb begin
        o_res.done = r_v[3];
        o_res.code = r_code;
        o_res.mv   = r_mv;
        o_res.temp = r_temp;
    end
endmodule
